/* hw/rtl/audio_volume_normalizer_defines.svh */
// Assertion macros shared by the volume normalizer RTL.
`ifndef AUDIO_VOLUME_NORMALIZER_DEFINES_SVH
`define AUDIO_VOLUME_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AVN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("avn assertion failed");

// Next-cycle implication, disabled during reset.
`define AVN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("avn assertion failed");

`endif

/* hw/rtl/avn_pkg.sv */
// Types and constants of the volume normalizer.
`default_nettype none
package avn_pkg;

    localparam int DIV_N_W   = 64;   // shared divider dividend / quotient
    localparam int DIV_D_W   = 40;   // shared divider divisor
    localparam int SQ_IN_W   = 48;   // square root radicand
    localparam int SQ_OUT_W  = 24;   // square root result
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 26;
    localparam int LVL_W     = 26;   // history level, Q18.8 (Q16.8 RMS scaled by gain)
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 3;

    localparam logic [15:0] GAIN_RESET   = 16'd8192;
    localparam logic [22:0] TARGET_RESET = 23'd2097088;
    localparam logic [22:0] SILENT_RESET = 23'd83884;
    localparam logic [15:0] WEIGHT_RESET = 16'd3932;
    localparam logic [15:0] GMIN_RESET   = 16'd819;
    localparam logic [15:0] GMAX_RESET   = 16'd40960;
    localparam logic [19:0] MINHL_RESET  = 20'd32000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD   = 3'd0,
        CFG_TARGET   = 3'd1,
        CFG_SILENCE  = 3'd2,
        CFG_WEIGHT   = 3'd3,
        CFG_GAIN_MIN = 3'd4,
        CFG_GAIN_MAX = 3'd5,
        CFG_MIN_HIST = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

endpackage
`default_nettype wire

/* hw/rtl/avn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module avn_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/avn_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module avn_div
    import avn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_N_W-1:0] i_dividend,
    input  wire logic [DIV_D_W-1:0] i_divisor,
    output logic      [DIV_N_W-1:0] o_quot,
    output t_iter_sts               o_sts
);
    localparam int CW = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] r_quot;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   rem_sh;
    logic               take;

    assign rem_sh = {r_rem, r_quot[DIV_N_W-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_rem  <= take ? DIV_D_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_D_W-1:0];
                r_quot <= {r_quot[DIV_N_W-2:0], take};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_sts  = '{busy: r_busy, done: r_done};
endmodule
`default_nettype wire

/* hw/rtl/avn_sqrt.sv */
// Integer square root, one result bit per cycle.
`default_nettype none
module avn_sqrt
    import avn_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SQ_IN_W-1:0]  i_radicand,
    output logic      [SQ_OUT_W-1:0] o_root,
    output t_iter_sts                o_sts
);
    localparam int CW = $clog2(SQ_OUT_W + 1);
    localparam int RW = SQ_OUT_W + 2;

    logic [SQ_IN_W-1:0]  r_rad;
    logic [RW-1:0]       r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [RW+1:0]       rem_sh;
    logic [RW+1:0]       trial;
    logic                take;

    assign rem_sh = {r_rem, r_rad[SQ_IN_W-1 -: 2]};
    assign trial  = (RW+2)'({r_root, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(SQ_OUT_W - 1);
            end else if (r_busy) begin
                r_rad  <= {r_rad[SQ_IN_W-3:0], 2'b00};
                r_rem  <= take ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
                r_root <= {r_root[SQ_OUT_W-2:0], take};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_sts  = '{busy: r_busy, done: r_done};
endmodule
`default_nettype wire

/* hw/rtl/audio_volume_normalizer.sv */
// Audio volume normalizer: two-pass RMS gain control over frames of 16-bit samples.
//
// Input stream: tdata = sample, tuser = mode (0 measure, 1 apply), tlast = last
// sample of the frame in this pass. Output stream: one item per apply sample,
// tdata = {gain_now, scaled_sample}, tlast = last_out. Measure items give none.
// Configuration: write i_cfg_data to register i_cfg_addr while i_cfg_we is high,
// only while no item is in flight.
// One item at a time: tready is high only while the sequencer is idle.
// Measure item: squared and accumulated. Last measure item in method 0: the
// shared divider forms the mean square and the square root its RMS; at or below
// the silence level that ends it, above it a second divider pass forms the gain
// (skipped on a zero denominator). In method 1: the same RMS, then a history
// sweep through the RAM read port and up to two divider passes.
// Apply item: the product is registered, then loaded into the output register;
// the history write follows on the frame's last sample. One shared registered
// multiplier serves every product. A stalled receiver holds the output
// register; the sequencer waits before loading the next result, and input stays
// blocked meanwhile. Reset (synchronous, active low) restores registers and
// gain of one, then clears every history RAM entry with tready low.
`default_nettype none
`include "audio_volume_normalizer_defines.svh"
module audio_volume_normalizer
    import avn_pkg::*;
#(
    parameter int FRAME_MAX     = 4096,
    parameter int HISTORY_DEPTH = 128
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [15:0]          i_s_axis_tdata,   // sample
    input  wire logic                 i_s_axis_tuser,   // mode
    input  wire logic                 i_s_axis_tlast,   // last
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [31:0]          o_m_axis_tdata,   // {gain_now, scaled_sample}
    output logic                      o_m_axis_tlast,   // last_out
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CNT_W  = $clog2(FRAME_MAX + 1);
    localparam int SUM_W  = 31 + CNT_W;
    localparam int HIDX_W = $clog2(HISTORY_DEPTH);
    localparam int TOT_W  = $clog2(HISTORY_DEPTH * FRAME_MAX + 1);
    localparam int WS_W   = LVL_W + TOT_W;
    localparam int HW_W   = LVL_W + CNT_W;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SQ, S_ACC, S_RMSDIV, S_RMSDIVW, S_SQRTW, S_UPD,
        S_M0DEN, S_M0DIV, S_M0DIVW, S_MIX1, S_MIX2, S_MIX3,
        S_M1RD, S_M1MUL, S_M1ACC, S_M1CHK, S_M1AVGW, S_M1GDIV, S_M1GDIVW,
        S_AMUL, S_AOUT, S_HLV, S_HWR
    } t_state;

    function automatic logic [15:0] clamp_gain(input logic [63:0] g,
                                               input logic [15:0] gmax,
                                               input logic [15:0] gmin);
        logic [63:0] v;
        v = g;
        if (v > 64'(gmax)) v = 64'(gmax);
        if (v < 64'(gmin)) v = 64'(gmin);
        return v[15:0];
    endfunction

    t_state              r_state;
    logic                r_method;
    logic [22:0]         r_target;
    logic [22:0]         r_silence;
    logic [15:0]         r_w;
    logic [15:0]         r_gmin;
    logic [15:0]         r_gmax;
    logic [19:0]         r_minhl;

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [15:0]         r_gain;
    logic [SQ_OUT_W-1:0] r_rms;
    logic [HIDX_W-1:0]   r_hidx;
    logic [HIDX_W-1:0]   r_sidx;
    logic [TOT_W-1:0]    r_tot;
    logic [WS_W-1:0]     r_wsum;
    logic [MUL_A_W-1:0]  r_need;
    logic [33:0]         r_t1;
    logic [PROD_W-1:0]   r_prod;

    logic [16:0]         r_smag;
    logic                r_sneg;
    logic                r_last;
    logic                r_counted;

    logic                r_ovalid;
    logic [31:0]         r_odata;
    logic                r_olast;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                div_start;
    logic [DIV_N_W-1:0]  div_n;
    logic [DIV_D_W-1:0]  div_d;
    logic [DIV_N_W-1:0]  div_q;
    t_iter_sts           div_sts;
    logic                sq_start;
    logic [SQ_OUT_W-1:0] sq_root;
    t_iter_sts           sq_sts;

    logic                ram_we;
    logic [HIDX_W-1:0]   ram_waddr;
    logic [HW_W-1:0]     ram_wdata;
    logic [HW_W-1:0]     ram_rdata;
    logic [LVL_W-1:0]    ram_level;
    logic [CNT_W-1:0]    ram_len;

    logic [16:0]         in_ext;
    logic [17:0]         sh;
    logic [15:0]         n_scaled;
    logic [49:0]         mix;
    logic                in_acc;
    logic                out_load;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_ext    = {i_s_axis_tdata[15], i_s_axis_tdata};
    assign ram_level = ram_rdata[HW_W-1:CNT_W];
    assign ram_len   = ram_rdata[CNT_W-1:0];
    assign mix       = 50'(r_t1) + 50'(r_prod[48:0]);
    assign out_load  = (r_state == S_AOUT) && (!r_ovalid || i_m_axis_tready);

    // Truncate toward zero, then saturate to int16.
    assign sh = r_prod[30:13];
    always_comb begin
        if (!r_sneg) begin
            n_scaled = (sh > 18'd32767) ? 16'h7FFF : sh[15:0];
        end else begin
            n_scaled = (sh >= 18'd32768) ? 16'h8000 : 16'(~sh[15:0] + 16'd1);
        end
    end

    // Operand select of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ:    begin mul_a = MUL_A_W'(r_smag);  mul_b = MUL_B_W'(r_smag); end
            S_M0DEN: begin mul_a = MUL_A_W'(r_gain);  mul_b = MUL_B_W'(r_rms);  end
            S_MIX1:  begin
                mul_a = MUL_A_W'(17'h10000 - 17'(r_w));
                mul_b = MUL_B_W'(r_gain);
            end
            S_MIX2:  begin mul_a = r_need;             mul_b = MUL_B_W'(r_w);    end
            S_M1MUL: begin mul_a = MUL_A_W'(ram_len);  mul_b = ram_level;        end
            // keep the product steady while the output register is busy
            S_AMUL, S_AOUT: begin
                mul_a = MUL_A_W'(r_smag);
                mul_b = MUL_B_W'(r_gain);
            end
            S_HLV:   begin mul_a = MUL_A_W'(r_gain);  mul_b = MUL_B_W'(r_rms);  end
            default: begin mul_a = '0;                 mul_b = '0;               end
        endcase
    end

    // Operand select and start of the shared divider.
    always_comb begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        unique case (r_state)
            S_RMSDIV: begin
                div_start = 1'b1;
                div_n     = DIV_N_W'({r_sum, 16'd0});
                div_d     = DIV_D_W'(r_cnt);
            end
            S_M0DIV: begin
                div_start = (r_prod[DIV_D_W-1:0] != '0);
                div_n     = DIV_N_W'({r_target, 26'd0});
                div_d     = r_prod[DIV_D_W-1:0];
            end
            S_M1CHK: begin
                div_start = 32'(r_tot) > 32'(r_minhl);
                div_n     = DIV_N_W'(r_wsum);
                div_d     = DIV_D_W'(r_tot);
            end
            S_M1GDIV: begin
                div_start = 1'b1;
                div_n     = DIV_N_W'({r_target, 13'd0});
                div_d     = DIV_D_W'(r_need);
            end
            default: begin
                div_start = 1'b0;
                div_n     = '0;
                div_d     = '0;
            end
        endcase
    end

    assign sq_start = (r_state == S_RMSDIVW) && div_sts.done;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sidx;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_HWR) begin
            ram_we    = 1'b1;
            ram_waddr = r_hidx;
            ram_wdata = {r_prod[LVL_W+12:13], r_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_method  <= 1'b0;
            r_target  <= TARGET_RESET;
            r_silence <= SILENT_RESET;
            r_w       <= WEIGHT_RESET;
            r_gmin    <= GMIN_RESET;
            r_gmax    <= GMAX_RESET;
            r_minhl   <= MINHL_RESET;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_gain    <= GAIN_RESET;
            r_rms     <= '0;
            r_hidx    <= '0;
            r_sidx    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_METHOD:   r_method  <= i_cfg_data[0];
                    CFG_TARGET:   r_target  <= i_cfg_data;
                    CFG_SILENCE:  r_silence <= i_cfg_data;
                    CFG_WEIGHT:   r_w       <= i_cfg_data[15:0];
                    CFG_GAIN_MIN: r_gmin    <= i_cfg_data[15:0];
                    CFG_GAIN_MAX: r_gmax    <= i_cfg_data[15:0];
                    CFG_MIN_HIST: r_minhl   <= i_cfg_data[19:0];
                    default:      ;
                endcase
            end

            if (r_ovalid && i_m_axis_tready && !out_load) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_sidx == HIDX_W'(HISTORY_DEPTH - 1)) begin
                        r_sidx  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_sidx <= r_sidx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_smag    <= in_ext[16] ? 17'(~in_ext + 17'd1) : in_ext;
                        r_sneg    <= in_ext[16];
                        r_last    <= i_s_axis_tlast;
                        r_counted <= r_cnt < CNT_W'(FRAME_MAX);
                        if (r_cnt < CNT_W'(FRAME_MAX)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= i_s_axis_tuser ? S_AMUL : S_SQ;
                    end
                end
                S_SQ: r_state <= S_ACC;
                S_ACC: begin
                    if (r_counted) begin
                        r_sum <= r_sum + SUM_W'(r_prod[30:0]);
                    end
                    r_state <= r_last ? S_RMSDIV : S_IDLE;
                end
                S_RMSDIV: r_state <= S_RMSDIVW;
                S_RMSDIVW: begin
                    if (div_sts.done) r_state <= S_SQRTW;
                end
                S_SQRTW: begin
                    if (sq_sts.done) begin
                        r_rms   <= sq_root;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_sidx <= '0;
                    r_tot  <= '0;
                    r_wsum <= '0;
                    if (r_method) begin
                        r_state <= S_M1RD;
                    end else if (r_rms > SQ_OUT_W'(r_silence)) begin
                        r_state <= S_M0DEN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_M0DEN: r_state <= S_M0DIV;
                S_M0DIV: begin
                    if (r_prod[DIV_D_W-1:0] == '0) begin
                        // zero denominator: largest need
                        r_need  <= MUL_A_W'(64'h1_0000_0000);
                        r_state <= S_MIX1;
                    end else begin
                        r_state <= S_M0DIVW;
                    end
                end
                S_M0DIVW: begin
                    if (div_sts.done) begin
                        r_need  <= (div_q > 64'h1_0000_0000) ? MUL_A_W'(64'h1_0000_0000)
                                                             : div_q[MUL_A_W-1:0];
                        r_state <= S_MIX1;
                    end
                end
                S_MIX1: r_state <= S_MIX2;
                S_MIX2: begin
                    r_t1    <= r_prod[33:0];
                    r_state <= S_MIX3;
                end
                S_MIX3: begin
                    r_gain  <= clamp_gain(64'(mix[49:16]), r_gmax, r_gmin);
                    r_state <= S_IDLE;
                end
                S_M1RD: r_state <= S_M1MUL;
                S_M1MUL: begin
                    r_tot   <= r_tot + TOT_W'(ram_len);
                    r_state <= S_M1ACC;
                end
                S_M1ACC: begin
                    r_wsum <= r_wsum + WS_W'(r_prod[LVL_W+CNT_W-1:0]);
                    if (r_sidx == HIDX_W'(HISTORY_DEPTH - 1)) begin
                        r_sidx  <= '0;
                        r_state <= S_M1CHK;
                    end else begin
                        r_sidx  <= r_sidx + 1'b1;
                        r_state <= S_M1RD;
                    end
                end
                S_M1CHK: r_state <= div_start ? S_M1AVGW : S_IDLE;
                S_M1AVGW: begin
                    if (div_sts.done) begin
                        r_need <= div_q[MUL_A_W-1:0];
                        if (div_q < 64'(r_silence)) begin
                            r_state <= S_IDLE;
                        end else if (div_q == '0) begin
                            r_gain  <= clamp_gain(64'(r_gmax), r_gmax, r_gmin);
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_M1GDIV;
                        end
                    end
                end
                S_M1GDIV: r_state <= S_M1GDIVW;
                S_M1GDIVW: begin
                    if (div_sts.done) begin
                        r_gain  <= clamp_gain(div_q, r_gmax, r_gmin);
                        r_state <= S_IDLE;
                    end
                end
                S_AMUL: r_state <= S_AOUT;
                S_AOUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_gain, n_scaled};
                        r_olast  <= r_last;
                        r_state  <= r_last ? S_HLV : S_IDLE;
                    end
                end
                S_HLV: r_state <= S_HWR;
                S_HWR: begin
                    r_hidx  <= (r_hidx == HIDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                       : r_hidx + 1'b1;
                    r_cnt   <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    avn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_quot     (div_q),
        .o_sts      (div_sts)
    );

    avn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (div_q[SQ_IN_W-1:0]),
        .o_root     (sq_root),
        .o_sts      (sq_sts)
    );

    avn_ram #(
        .WIDTH (HW_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_sidx),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    `AVN_ASSERT_IMPL(a_div_idle, i_clk, i_rst_n, div_start, !div_sts.busy)
    `AVN_ASSERT_IMPL(a_sqrt_idle, i_clk, i_rst_n, sq_start, !sq_sts.busy)
    `AVN_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_acc, !o_s_axis_tready)
    `AVN_ASSERT_IMPL(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !o_m_axis_tvalid && !o_s_axis_tready)
endmodule
`default_nettype wire

/* tb/tb_audio_volume_normalizer.sv */
// Self-checking testbench for the two-pass audio volume normalizer.
`timescale 1ns / 1ps
module tb_audio_volume_normalizer;
    import avn_pkg::*;

    typedef struct {
        logic        mode;
        logic [15:0] sample;
        logic        last;
    } t_audio_item;

    typedef struct {
        logic [15:0] scaled;
        logic        last;
        logic [15:0] gain;
    } t_scaled_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [15:0]          s_data = '0;
    logic                 s_user = 1'b0;
    logic                 s_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [31:0]          m_data;
    logic                 m_last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = CFG_METHOD;
    logic [CFG_W-1:0]     cfg_data = '0;

    audio_volume_normalizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of configuration and state
    logic        p_method;
    logic [22:0] p_target, p_silence;
    logic [15:0] p_weight, p_gmin, p_gmax;
    logic [19:0] p_minhist;
    logic [63:0] sq_acc;
    int unsigned smp_cnt;
    logic [15:0] cur_gain;
    logic [63:0] rms_q;
    logic [63:0] hist_lvl [128];
    logic [63:0] hist_len [128];
    logic [6:0]  hist_ptr;

    t_audio_item  pend_items[$];
    t_scaled_item exp_scaled[$];
    t_audio_item  cur_item;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_trig = 0, hold_seen = 0, hold_cnt = 0;
    int  errors = 0, n_results = 0, n_items = 0;
    bit  take;

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp_gain(logic [63:0] g);
        if (g > p_gmax) g = p_gmax;
        if (g < p_gmin) g = p_gmin;
        return g[15:0];
    endfunction

    function automatic void update_gain();
        logic [63:0] den, need, mix, total, wsum, avg, g;
        if (p_method == 1'b0) begin
            if (rms_q > p_silence) begin
                den  = rms_q * cur_gain;
                need = 64'd1 << 32;
                if (den != 0) begin
                    need = ({41'd0, p_target} << 26) / den;
                    if (need > (64'd1 << 32)) need = 64'd1 << 32;
                end
                mix = ((64'd65536 - p_weight) * cur_gain + p_weight * need) >> 16;
                cur_gain = clamp_gain(mix);
            end
        end else begin
            total = 0;
            wsum  = 0;
            for (int i = 0; i < 128; i++) begin
                total += hist_len[i];
                wsum  += hist_lvl[i] * hist_len[i];
            end
            if (total > p_minhist) begin
                avg = wsum / total;
                if (avg >= p_silence) begin
                    g = p_gmax;
                    if (avg != 0) g = ({41'd0, p_target} << 13) / avg;
                    cur_gain = clamp_gain(g);
                end
            end
        end
    endfunction

    // advance the model by one accepted item and queue its result if it is an apply item
    function automatic void predict_scaled(t_audio_item it);
        bit           counted;
        longint       s, v;
        logic [63:0]  mag;
        t_scaled_item r;
        counted = 0;
        s = $signed(it.sample);
        if (smp_cnt < 4096) begin
            smp_cnt++;
            counted = 1;
        end
        if (it.mode == 1'b0) begin
            if (counted) sq_acc += s * s;
            if (it.last) begin
                rms_q = root64((sq_acc << 16) / smp_cnt);
                update_gain();
                sq_acc  = 0;
                smp_cnt = 0;
            end
        end else begin
            mag = (s < 0 ? -s : s) * cur_gain;
            v = mag >> 13;
            if (s < 0) v = -v;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.scaled = v[15:0];
            r.last   = it.last;
            r.gain   = cur_gain;
            exp_scaled.push_back(r);
            if (it.last) begin
                hist_lvl[hist_ptr] = (cur_gain * rms_q) >> 13;
                hist_len[hist_ptr] = smp_cnt;
                hist_ptr++;
                smp_cnt = 0;
            end
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                predict_scaled(cur_item);
                n_items++;
            end
            if (!s_valid || take) begin
                if (pend_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pend_items.pop_front();
                    s_data  <= cur_item.sample;
                    s_user  <= cur_item.mode;
                    s_last  <= cur_item.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_trig) begin
            hold_seen = hold_trig;
            hold_cnt  = 1500;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            n_results++;
            if (exp_scaled.size() == 0) begin
                $display("%0t: unexpected item: got %h last %b", $realtime, m_data, m_last);
                errors++;
            end else begin
                t_scaled_item e;
                e = exp_scaled.pop_front();
                if (m_data[15:0] !== e.scaled) begin
                    $display("%0t: scaled_sample expected %h actual %h",
                             $realtime, e.scaled, m_data[15:0]);
                    errors++;
                end
                if (m_data[31:16] !== e.gain) begin
                    $display("%0t: gain_now expected %h actual %h",
                             $realtime, e.gain, m_data[31:16]);
                    errors++;
                end
                if (m_last !== e.last) begin
                    $display("%0t: last_out expected %b actual %b", $realtime, e.last, m_last);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[22:0];
        case (idx)
            CFG_METHOD:   p_method  = val[0];
            CFG_TARGET:   p_target  = val[22:0];
            CFG_SILENCE:  p_silence = val[22:0];
            CFG_WEIGHT:   p_weight  = val[15:0];
            CFG_GAIN_MIN: p_gmin    = val[15:0];
            CFG_GAIN_MAX: p_gmax    = val[15:0];
            CFG_MIN_HIST: p_minhist = val[19:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(logic mode, logic [15:0] smp, logic last);
        t_audio_item it;
        it.mode   = mode;
        it.sample = smp;
        it.last   = last;
        pend_items.push_back(it);
    endtask

    function automatic logic [15:0] pick_sample(int kind);
        case (kind)
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(2 * kind + 40) - 20);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            3: return 16'd0;
            default: return 16'($urandom_range(4000) - 2000);
        endcase
    endfunction

    // measure pass then apply pass over the same samples
    task automatic push_frame(int len, int kind);
        logic [15:0] smp [$];
        for (int i = 0; i < len; i++) smp.push_back(pick_sample(kind));
        for (int i = 0; i < len; i++) push_item(1'b0, smp[i], i == len - 1);
        for (int i = 0; i < len; i++) push_item(1'b1, smp[i], i == len - 1);
    endtask

    task automatic push_random(int n_target);
        int k;
        k = 0;
        while (k < n_target) begin
            if ($urandom_range(99) < 15) begin
                // mixed-mode noise with random frame ends
                repeat ($urandom_range(12, 1)) begin
                    push_item(1'($urandom_range(1)), 16'($urandom_range(65535)),
                              $urandom_range(5) == 0);
                    k++;
                end
            end else begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(12, 1);
                push_frame(len, $urandom_range(4));
                k += 2 * len;
            end
        end
    endtask

    task automatic drain();
        while (pend_items.size() != 0 || s_valid || exp_scaled.size() != 0) @(posedge i_clk);
        // last measure item may still be busy on the gain update
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic set_idling(int ph);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    initial begin
        p_method  = 1'b0;
        p_target  = TARGET_RESET;
        p_silence = SILENT_RESET;
        p_weight  = WEIGHT_RESET;
        p_gmin    = GMIN_RESET;
        p_gmax    = GMAX_RESET;
        p_minhist = MINHL_RESET;
        sq_acc    = 0;
        smp_cnt   = 0;
        cur_gain  = GAIN_RESET;
        rms_q     = 0;
        hist_ptr  = 0;
        for (int i = 0; i < 128; i++) begin
            hist_lvl[i] = 0;
            hist_len[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, silent frame, mixed-mode frame, defaults
        push_item(1'b0, 16'h7fff, 1'b0);
        push_item(1'b0, 16'h8000, 1'b0);
        push_item(1'b0, 16'h0000, 1'b1);
        push_item(1'b1, 16'h8000, 1'b0);
        push_item(1'b1, 16'h7fff, 1'b0);
        push_item(1'b1, 16'h0001, 1'b0);
        push_item(1'b1, 16'hffff, 1'b1);
        push_frame(3, 3);
        push_item(1'b1, 16'h1234, 1'b0);
        push_item(1'b0, 16'h4000, 1'b1);
        push_frame(2, 2);
        drain();

        // method 0, fastest smoothing and widest clamp
        write_reg(CFG_WEIGHT, 65535);
        write_reg(CFG_GAIN_MIN, 1);
        write_reg(CFG_GAIN_MAX, 65535);
        write_reg(CFG_TARGET, 8388607);
        write_reg(CFG_SILENCE, 0);
        set_idling(1);
        push_random(150);
        drain();

        // crossed clamp bounds, with a long receiver hold-off
        write_reg(CFG_GAIN_MIN, 40000);
        write_reg(CFG_GAIN_MAX, 100);
        write_reg(CFG_WEIGHT, 1);
        set_idling(0);
        hold_trig++;
        push_random(120);
        drain();

        // method 1, no history minimum, silence at zero so zero means occur
        write_reg(CFG_METHOD, 1);
        write_reg(CFG_MIN_HIST, 0);
        write_reg(CFG_GAIN_MIN, 1);
        write_reg(CFG_GAIN_MAX, 65535);
        write_reg(CFG_TARGET, 2097088);
        set_idling(2);
        push_frame(4, 3);
        push_random(150);
        drain();

        // method 1 with a history minimum that is never exceeded
        write_reg(CFG_MIN_HIST, 524288);
        write_reg(CFG_SILENCE, 8388607);
        set_idling(3);
        push_random(100);
        drain();

        // method 1, moderate minimum, zero target
        write_reg(CFG_MIN_HIST, 200);
        write_reg(CFG_SILENCE, 20);
        write_reg(CFG_TARGET, 0);
        set_idling(1);
        push_random(80);
        drain();

        // back to method 0 with defaults
        write_reg(CFG_METHOD, 0);
        write_reg(CFG_TARGET, TARGET_RESET);
        write_reg(CFG_SILENCE, SILENT_RESET);
        write_reg(CFG_WEIGHT, WEIGHT_RESET);
        write_reg(CFG_GAIN_MIN, GMIN_RESET);
        write_reg(CFG_GAIN_MAX, GMAX_RESET);
        write_reg(CFG_MIN_HIST, MINHL_RESET);
        set_idling(3);
        push_random(120);
        drain();

        $display("covered %0d input items and %0d output items", n_items, n_results);
        $display("both gain methods, crossed clamps, silent and mixed-mode frames, stalls");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/avn_pkg.sv
hw/rtl/avn_ram.sv
hw/rtl/avn_div.sv
hw/rtl/avn_sqrt.sv
hw/rtl/audio_volume_normalizer.sv
tb/tb_audio_volume_normalizer.sv
